/* src/lcc_pkg.sv */
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and codes for the column-clear line stepper.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int COORD_W = 10;
    localparam int DEC_W   = 13;

    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic signed [DEC_W-1:0]   decision_t;

    // request kind codes
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // minor axis direction codes
    localparam logic DIR_POS = 1'b0;
    localparam logic DIR_NEG = 1'b1;

    typedef struct packed {
        logic   kind;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } req_t;

    typedef struct packed {
        logic   clear_valid;
        coord_t column;
        coord_t bottom_row;
        logic   last;
    } rsp_t;

endpackage

/* src/line_column_clear_stepper.sv */
// ----------------------------------------------------------------------------
// line_column_clear_stepper
// Bresenham line walker over all octants that issues column-clear commands.
// Input channel (s_*): a load request (kind 0) takes two endpoints and starts
// a new line, replacing any line in progress; it returns nothing. A step
// request (kind 1) advances one position on the major axis and returns one
// response on the m_* channel while a line is active, none otherwise.
// Shallow lines clear rows 0..y of column x on every step whose x is inside
// the image; steep lines issue a clear only on steps where x moves. m_last marks the final step.
// Response path: an accepted request passes the input register, then the
// response register, which drives m_valid.
// Throughput: one request per cycle unless the receiver stalls; the error term
// update is a single add and compare, closed in the stage after the input
// register. When the receiver stalls, the response register holds and the
// input register fills, then s_ready drops; no response is lost or repeated.
// Reset clears the pipeline valids and the line state (no line loaded).
// ----------------------------------------------------------------------------
module line_column_clear_stepper #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  lcc_pkg::coord_t      s_x_start,
    input  lcc_pkg::coord_t      s_y_start,
    input  lcc_pkg::coord_t      s_x_end,
    input  lcc_pkg::coord_t      s_y_end,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_clear_valid,
    output lcc_pkg::coord_t      m_column,
    output lcc_pkg::coord_t      m_bottom_row,
    output logic                 m_last
);
    import lcc_pkg::*;

    // limits widened so any parameter value in range compares correctly
    localparam int            LIM_W     = 17;
    localparam logic [LIM_W-1:0] WIDTH_LIM = LIM_W'(IMAGE_WIDTH);
    localparam logic [LIM_W-1:0] ROW_LIM   = LIM_W'(IMAGE_HEIGHT - 1);
    localparam coord_t        COORD_MAX = {COORD_W{1'b1}};

    // input register
    logic      in_valid_reg;
    req_t      in_reg;

    // line state
    logic      active_reg,      active_next;
    logic      steep_reg,       steep_next;
    logic      minor_dir_reg,   minor_dir_next;
    coord_t    cur_x_reg,       cur_x_next;
    coord_t    cur_y_reg,       cur_y_next;
    coord_t    major_end_reg,   major_end_next;
    coord_t    delta_major_reg, delta_major_next;
    coord_t    delta_minor_reg, delta_minor_next;
    decision_t decision_reg,    decision_next;

    // response register
    logic      out_valid_reg;
    rsp_t      out_reg, rsp_next;

    logic      produce;
    logic      advance;

    // ------------------------------------------------------------------
    // handshake: a request that yields no response never waits on m_ready
    // ------------------------------------------------------------------
    assign produce = (in_reg.kind == KIND_STEP) && active_reg;
    assign advance = in_valid_reg && (!produce || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= '{kind: s_kind, x_start: s_x_start, y_start: s_y_start,
                        x_end: s_x_end, y_end: s_y_end};
        end
    end

    // ------------------------------------------------------------------
    // load and step datapath
    // ------------------------------------------------------------------
    coord_t    dxa, dya, xa, ya, xb, yb;
    logic      ld_steep, ld_swap;
    logic      dec_pos;
    decision_t dec_inc_diag, dec_inc_axis;
    coord_t    mv;
    logic      mv_out;
    logic      col_in;
    coord_t    row_clamped;

    always_comb begin
        dxa = (in_reg.x_start > in_reg.x_end) ? in_reg.x_start - in_reg.x_end
                                              : in_reg.x_end - in_reg.x_start;
        dya = (in_reg.y_start > in_reg.y_end) ? in_reg.y_start - in_reg.y_end
                                              : in_reg.y_end - in_reg.y_start;
        // equal deltas, including a single point, take the steep form
        ld_steep = !(dya < dxa);
        ld_swap  = ld_steep ? (in_reg.y_start > in_reg.y_end)
                            : (in_reg.x_start > in_reg.x_end);
        xa = ld_swap ? in_reg.x_end   : in_reg.x_start;
        ya = ld_swap ? in_reg.y_end   : in_reg.y_start;
        xb = ld_swap ? in_reg.x_start : in_reg.x_end;
        yb = ld_swap ? in_reg.y_start : in_reg.y_end;

        dec_pos      = !decision_reg[DEC_W-1] && (decision_reg != '0);
        dec_inc_axis = decision_t'({2'b00, delta_minor_reg, 1'b0});
        dec_inc_diag = decision_t'({2'b00, delta_minor_reg, 1'b0})
                     - decision_t'({2'b00, delta_major_reg, 1'b0});

        // steep minor move; stepping off either edge of the coordinate range
        mv     = (minor_dir_reg == DIR_NEG) ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
        mv_out = (minor_dir_reg == DIR_NEG) ? (cur_x_reg == '0)
                                            : (cur_x_reg == COORD_MAX);

        col_in      = (LIM_W'(steep_reg ? mv : cur_x_reg) < WIDTH_LIM);
        row_clamped = (LIM_W'(cur_y_reg) > ROW_LIM) ? ROW_LIM[COORD_W-1:0]
                                                    : cur_y_reg;
    end

    always_comb begin
        active_next      = active_reg;
        steep_next       = steep_reg;
        minor_dir_next   = minor_dir_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        major_end_next   = major_end_reg;
        delta_major_next = delta_major_reg;
        delta_minor_next = delta_minor_reg;
        decision_next    = decision_reg;
        rsp_next         = '0;

        if (in_reg.kind == KIND_LOAD) begin
            active_next      = 1'b1;
            steep_next       = ld_steep;
            minor_dir_next   = ld_steep ? ((xb < xa) ? DIR_NEG : DIR_POS)
                                        : ((yb < ya) ? DIR_NEG : DIR_POS);
            major_end_next   = ld_steep ? yb : xb;
            delta_major_next = ld_steep ? dya : dxa;
            delta_minor_next = ld_steep ? dxa : dya;
            cur_x_next       = xa;
            cur_y_next       = ya;
            decision_next    = decision_t'({2'b00, delta_minor_next, 1'b0})
                             - decision_t'({3'b000, delta_major_next});
        end else if (active_reg) begin
            if (!steep_reg) begin
                // shallow: clear at the position before the minor update
                if (col_in) begin
                    rsp_next.clear_valid = 1'b1;
                    rsp_next.column      = cur_x_reg;
                    rsp_next.bottom_row  = row_clamped;
                end
                if (dec_pos) begin
                    cur_y_next    = (minor_dir_reg == DIR_NEG) ? cur_y_reg - 1'b1
                                                               : cur_y_reg + 1'b1;
                    decision_next = decision_reg + dec_inc_diag;
                end else begin
                    decision_next = decision_reg + dec_inc_axis;
                end
                rsp_next.last = (cur_x_reg == major_end_reg);
                cur_x_next    = cur_x_reg + 1'b1;
            end else begin
                // steep: clear only when x moves, at the new x
                if (dec_pos) begin
                    if (!mv_out && col_in) begin
                        rsp_next.clear_valid = 1'b1;
                        rsp_next.column      = mv;
                        rsp_next.bottom_row  = row_clamped;
                    end
                    cur_x_next    = mv;
                    decision_next = decision_reg + dec_inc_diag;
                end else begin
                    decision_next = decision_reg + dec_inc_axis;
                end
                rsp_next.last = (cur_y_reg == major_end_reg);
                cur_y_next    = cur_y_reg + 1'b1;
            end
            if (rsp_next.last) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            steep_reg       <= 1'b0;
            minor_dir_reg   <= DIR_POS;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            major_end_reg   <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            decision_reg    <= '0;
        end else if (advance) begin
            active_reg      <= active_next;
            steep_reg       <= steep_next;
            minor_dir_reg   <= minor_dir_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            major_end_reg   <= major_end_next;
            delta_major_reg <= delta_major_next;
            delta_minor_reg <= delta_minor_next;
            decision_reg    <= decision_next;
        end
    end

    // ------------------------------------------------------------------
    // response register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && produce) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && produce) begin
            out_reg <= rsp_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_clear_valid = out_reg.clear_valid;
    assign m_column      = out_reg.column;
    assign m_bottom_row  = out_reg.bottom_row;
    assign m_last        = out_reg.last;

endmodule
